@@ rtl/core/mcsg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcsg_pkg
// Shared types and constants for the MIDI clock and song position generator.
// ----------------------------------------------------------------------------
package mcsg_pkg;

	localparam int TPB_W   = 5;   // ticks-per-beat register width
	localparam int ROWF_W  = 16;  // row field width on the input beat
	localparam int SPT_W   = 16;  // samples per tick
	localparam int DATA_W  = 7;   // MIDI data byte payload
	localparam int POS_W   = 2 * DATA_W;
	localparam int OFS_W   = 16;
	localparam int CNT_W   = 5;   // clocks per tick, 0..24

	// Divider operand widths: row*6 needs 19 bits
	localparam int DIV_W   = 19;
	localparam int DSR_W   = 5;

	localparam int POS_UNITS = 6; // song position units per beat

	localparam int CMDQ_DEPTH = 2;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TPB_IDX = 1'b0;
	localparam logic [TPB_W-1:0] TPB_RESET = 5'd4;

	// MIDI status codes
	localparam logic [7:0] ST_POSITION = 8'hF2;
	localparam logic [7:0] ST_CONTINUE = 8'hFB;
	localparam logic [7:0] ST_STOP     = 8'hFC;
	localparam logic [7:0] ST_CLOCK    = 8'hF8;

	typedef struct packed {
		logic               transport_running;
		logic [ROWF_W-1:0]  seq_row;
		logic [SPT_W-1:0]   tick_samples;
	} item_t;

	typedef struct packed {
		logic [7:0]         status_byte;
		logic [DATA_W-1:0]  data_low;
		logic [DATA_W-1:0]  data_high;
		logic [OFS_W-1:0]   sample_offset;
		logic               last_of_run;
	} result_t;

	// Classified tick, front to back
	typedef struct packed {
		logic               pos;
		logic               cont;
		logic               stop;
		logic               clk;
		logic [ROWF_W-1:0]  row;
		logic [SPT_W-1:0]   spt;
	} cmd_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   dividend;
		logic [DSR_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_W-1:0]   quotient;
		logic [DSR_W-1:0]   remainder;
	} div_rsp_t;

	// Beat clocks per tick: 24 / beat_ticks, zero treated as one
	function automatic logic [CNT_W-1:0] clocks_per_tick(input logic [TPB_W-1:0] tpb);
		logic [CNT_W-1:0] c;
		unique case (tpb)
			5'd0, 5'd1:                 c = 5'd24;
			5'd2:                       c = 5'd12;
			5'd3:                       c = 5'd8;
			5'd4:                       c = 5'd6;
			5'd5, 5'd6:                 c = 5'd4;
			5'd7, 5'd8:                 c = 5'd3;
			5'd9, 5'd10, 5'd11, 5'd12:  c = 5'd2;
			5'd13, 5'd14, 5'd15, 5'd16,
			5'd17, 5'd18, 5'd19, 5'd20,
			5'd21, 5'd22, 5'd23, 5'd24: c = 5'd1;
			default:                    c = 5'd0;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/mcsg_front.sv @@
// ----------------------------------------------------------------------------
// mcsg_front
// Takes tick beats, tracks transport and row, and classifies each tick into
// the messages it needs.
// ----------------------------------------------------------------------------
module mcsg_front import mcsg_pkg::*; #(
	parameter int ROW_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  push,
	input  logic  q_full,
	output cmd_t  cmd,
	output logic  cmd_push
);

	logic                running_q;
	logic [ROW_BITS-1:0] prev_row_q;
	logic [ROW_BITS-1:0] row_w;
	logic [ROW_BITS-1:0] row_inc;
	logic                accept;
	logic                run;
	logic                start;

	assign accept  = push && !q_full;
	assign run     = item.transport_running;
	assign start   = run && !running_q;
	assign row_w   = ROW_BITS'(item.seq_row);
	assign row_inc = prev_row_q + ROW_BITS'(1);

	always_comb begin
		cmd.cont = start;
		cmd.stop = !run && running_q;
		cmd.pos  = start || (run && running_q && (row_inc != row_w));
		cmd.clk  = run;
		cmd.row  = ROWF_W'(row_w);
		cmd.spt  = item.tick_samples;
	end

	// ticks with nothing to say are dropped here
	assign cmd_push = accept && (cmd.pos || cmd.cont || cmd.stop || cmd.clk);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			prev_row_q <= '0;
		end else if (accept) begin
			running_q <= run;
			if (run) begin
				prev_row_q <= row_w;
			end
		end
	end

endmodule

@@ rtl/core/mcsg_cmdq.sv @@
// ----------------------------------------------------------------------------
// mcsg_cmdq
// Short command queue between the classifier and the message sequencer.
// ----------------------------------------------------------------------------
module mcsg_cmdq import mcsg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t wr_cmd,
	input  logic wr_en,
	output logic full,
	output cmd_t rd_cmd,
	output logic rd_valid,
	input  logic rd_en
);

	localparam int PTR_W = $clog2(CMDQ_DEPTH);

	cmd_t             ent_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (cnt_q == (PTR_W+1)'(CMDQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = ent_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/mcsg_div.sv @@
// ----------------------------------------------------------------------------
// mcsg_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module mcsg_div import mcsg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DSR_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, dsr_q});

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
		end
	end

endmodule

@@ rtl/core/mcsg_back.sv @@
// ----------------------------------------------------------------------------
// mcsg_back
// Message sequencer: turns one classified tick into position, continue,
// stop and clock messages, and holds the result output register.
// ----------------------------------------------------------------------------
module mcsg_back import mcsg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [TPB_W-1:0] tpb,
	input  cmd_t             cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	output result_t          result,
	output logic             empty,
	input  logic             pop
);

	typedef enum logic [2:0] {
		S_IDLE, S_POS_DIV, S_POS_EMIT, S_CONT, S_STOP, S_CLK_DIV, S_CLK0, S_CLKN
	} state_t;

	// pending work, in message order
	localparam logic [3:0] M_POS  = 4'b1000;
	localparam logic [3:0] M_CONT = 4'b0100;
	localparam logic [3:0] M_STOP = 4'b0010;
	localparam logic [3:0] M_CLK  = 4'b0001;

	state_t           state_q;
	logic [3:0]       todo_q;
	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [OFS_W-1:0] qs_q;
	logic [CNT_W-1:0] rs_q;
	logic [OFS_W-1:0] acc_q;
	logic [CNT_W-1:0] accr_q;
	logic [CNT_W-1:0] idx_q;
	result_t          out_q;
	logic             out_valid_q;
	div_req_t         div_req_q;
	div_rsp_t         div_rsp;

	logic [TPB_W-1:0] eff_tpb;
	logic [CNT_W-1:0] count;
	logic             multi;
	logic             out_free;
	cmd_t             go_cmd;
	logic [3:0]       go_todo;
	state_t           go_state;
	logic             advance;
	logic [CNT_W:0]   sum_r;
	logic             wrap;
	logic [OFS_W-1:0] acc_step;
	logic [CNT_W-1:0] accr_step;
	logic             last_clk;

	function automatic state_t first_step(input logic [3:0] t, input logic m);
		state_t s;
		priority if ((t & M_POS)  != '0) s = S_POS_DIV;
		else if     ((t & M_CONT) != '0) s = S_CONT;
		else if     ((t & M_STOP) != '0) s = S_STOP;
		else if     ((t & M_CLK)  != '0) s = m ? S_CLK_DIV : S_CLK0;
		else                             s = S_IDLE;
		return s;
	endfunction

	mcsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign eff_tpb  = (tpb == '0) ? TPB_W'(1) : tpb;
	assign count    = clocks_per_tick(tpb);
	assign multi    = (count >= CNT_W'(2));
	assign out_free = !out_valid_q || pop;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign go_cmd   = (state_q == S_IDLE) ? cmd : cmd_q;
	assign last_clk = (idx_q == count - CNT_W'(1));

	// offset i = floor(i*spt/count), stepped by spt/count with remainder carry
	assign sum_r     = {1'b0, accr_q} + {1'b0, rs_q};
	assign wrap      = (sum_r >= {1'b0, count});
	assign acc_step  = acc_q + qs_q + OFS_W'(wrap);
	assign accr_step = wrap ? CNT_W'(sum_r - {1'b0, count}) : sum_r[CNT_W-1:0];

	always_comb begin
		go_todo = todo_q;
		advance = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				go_todo = {cmd.pos, cmd.cont, cmd.stop, cmd.clk};
				advance = cmd_valid;
			end
			S_POS_EMIT: begin
				go_todo = todo_q & ~M_POS;
				advance = out_free;
			end
			S_CONT: begin
				go_todo = todo_q & ~M_CONT;
				advance = out_free;
			end
			S_STOP: begin
				go_todo = todo_q & ~M_STOP;
				advance = out_free;
			end
			default: begin
				go_todo = todo_q;
				advance = 1'b0;
			end
		endcase
		go_state = first_step(go_todo, multi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			todo_q          <= '0;
			out_valid_q     <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end

			if (advance) begin
				todo_q  <= go_todo;
				state_q <= go_state;
				if (go_state == S_POS_DIV) begin
					div_req_q.start    <= 1'b1;
					div_req_q.dividend <= DIV_W'(go_cmd.row) * DIV_W'(POS_UNITS);
					div_req_q.divisor  <= DSR_W'(eff_tpb);
				end else if (go_state == S_CLK_DIV) begin
					div_req_q.start    <= 1'b1;
					div_req_q.dividend <= DIV_W'(go_cmd.spt);
					div_req_q.divisor  <= DSR_W'(count);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
					end
				end
				S_POS_DIV: begin
					if (div_rsp.done) begin
						pos_q   <= div_rsp.quotient[POS_W-1:0];
						state_q <= S_POS_EMIT;
					end
				end
				S_POS_EMIT: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.status_byte    <= ST_POSITION;
						out_q.data_low       <= pos_q[DATA_W-1:0];
						out_q.data_high      <= pos_q[POS_W-1:DATA_W];
						out_q.sample_offset  <= '0;
						out_q.last_of_run    <= (go_todo == '0);
					end
				end
				S_CONT: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.status_byte    <= ST_CONTINUE;
						out_q.data_low       <= '0;
						out_q.data_high      <= '0;
						out_q.sample_offset  <= '0;
						out_q.last_of_run    <= (go_todo == '0);
					end
				end
				S_STOP: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.status_byte    <= ST_STOP;
						out_q.data_low       <= '0;
						out_q.data_high      <= '0;
						out_q.sample_offset  <= '0;
						out_q.last_of_run    <= (go_todo == '0);
					end
				end
				S_CLK_DIV: begin
					if (div_rsp.done) begin
						qs_q    <= div_rsp.quotient[OFS_W-1:0];
						rs_q    <= CNT_W'(div_rsp.remainder);
						acc_q   <= '0;
						accr_q  <= '0;
						state_q <= S_CLK0;
					end
				end
				S_CLK0: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.status_byte    <= ST_CLOCK;
						out_q.data_low       <= '0;
						out_q.data_high      <= '0;
						out_q.sample_offset  <= '0;
						out_q.last_of_run    <= !multi;
						if (multi) begin
							acc_q   <= acc_step;
							accr_q  <= accr_step;
							idx_q   <= CNT_W'(1);
							state_q <= S_CLKN;
						end else begin
							todo_q  <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_CLKN: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.status_byte    <= ST_CLOCK;
						out_q.data_low       <= '0;
						out_q.data_high      <= '0;
						out_q.sample_offset  <= acc_q;
						out_q.last_of_run    <= last_clk;
						acc_q  <= acc_step;
						accr_q <= accr_step;
						idx_q  <= idx_q + CNT_W'(1);
						if (last_clk) begin
							todo_q  <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule

@@ rtl/core/midi_clock_sync_generator.sv @@
// ----------------------------------------------------------------------------
// midi_clock_sync_generator
// MIDI beat clock and song position generator: one tick beat in, a run of
// position / continue / stop / clock message beats out.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  tick in  | push / full            | item   (item_t: run, row, samples)
//  msg out  | pop / empty            | result (result_t: status, data,
//           |                        |         offset, last)
//  config   | APB psel/penable/...   | beat_ticks at byte address 0
//
// A tick beat is taken into a two-deep command queue. The sequencer takes a
// command only when idle, runs each division on the shared 19-bit radix-2
// divider (position, and clock spacing when more than one clock is due), and
// emits the message beats; it takes no new command until its last beat is out.
// Reset puts the ticks-per-beat register at 4 and clears transport state.
// A stalled result side fills the queue and raises full; push side stalls
// never block messages already queued.
//
module midi_clock_sync_generator import mcsg_pkg::*; #(
	parameter int ROW_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// tick beats
	input  item_t              item,
	input  logic               push,
	output logic               full,
	// message beats
	output result_t            result,
	output logic               empty,
	input  logic               pop,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [TPB_W-1:0] tpb_q;
	logic             reg_hit;
	cmd_t             f_cmd;
	logic             f_push;
	cmd_t             q_cmd;
	logic             q_valid;
	logic             q_pop;

	// --- configuration register -------------------------------------------
	// Only word index 0 exists; low byte-address bits are not decoded.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_TPB_IDX);
	assign prdata  = reg_hit ? PDATA_W'(tpb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q <= TPB_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			tpb_q <= pwdata[TPB_W-1:0];
		end
	end

	// --- front: transport tracking and classification ---------------------
	mcsg_front #(
		.ROW_BITS (ROW_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.q_full   (full),
		.cmd      (f_cmd),
		.cmd_push (f_push)
	);

	// --- decoupling queue ---------------------------------------------------
	mcsg_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (f_cmd),
		.wr_en    (f_push),
		.full     (full),
		.rd_cmd   (q_cmd),
		.rd_valid (q_valid),
		.rd_en    (q_pop)
	);

	// --- back: message sequencing, divider and output register -------------
	mcsg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tpb       (tpb_q),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

`ifndef ASSERT_OFF
	// every message beat carries one of the four status codes
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status_byte == ST_POSITION || result.status_byte == ST_CONTINUE ||
			result.status_byte == ST_STOP || result.status_byte == ST_CLOCK))
		else $error("illegal status byte on result");

	// only clock beats may carry a nonzero sample offset
	a_offset_clock_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status_byte != ST_CLOCK) |-> (result.sample_offset == '0))
		else $error("nonzero offset on non-clock message");

	// continue is always followed by the clocks of the starting tick
	a_cont_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status_byte == ST_CONTINUE) |-> !result.last_of_run)
		else $error("continue flagged as last of run");

	// data bytes are zero except on song position
	a_data_pos_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status_byte != ST_POSITION) |->
			(result.data_low == '0 && result.data_high == '0))
		else $error("data bytes set on non-position message");
`endif

endmodule
